// File: src/rate_feedback_torque_law_core_defines.svh
// Assertion macros for the rate feedback torque law core.
// Included by the top level; depends on nothing else.
`ifndef RATE_FEEDBACK_TORQUE_LAW_CORE_DEFINES_SVH
`define RATE_FEEDBACK_TORQUE_LAW_CORE_DEFINES_SVH

// Condition implies a consequence in the same cycle.
`define RFTL_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies a consequence delayed by the argument n.
`define RFTL_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// File: src/rftl_pkg.sv
// Package for the rate feedback torque law core: fixed-point types, register
// codes and the rounding multiply and saturation helpers. Depends on nothing.
package rftl_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FIX_W     = 32;
   localparam int PROD_W    = 2 * FIX_W - FRAC_BITS;
   localparam int SUM_W     = PROD_W + 2;
   localparam int LATENCY   = 7;
   localparam int ADDR_W    = 6;
   localparam int DATA_W    = 64;

   typedef logic signed [FIX_W-1:0]   fix_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [2*FIX_W-1:0] wide_type;

   typedef enum logic [2:0] {
      REG_RATE_GAIN     = 3'd0,
      REG_INERTIA_XX_YY = 3'd1,
      REG_INERTIA_ZZ_XY = 3'd2,
      REG_INERTIA_XZ_YZ = 3'd3,
      REG_KNOWN_TORQ_X  = 3'd4,
      REG_KNOWN_TORQ_Y  = 3'd5,
      REG_KNOWN_TORQ_Z  = 3'd6,
      REG_NONE          = 3'd7
   } reg_index_type;

   localparam fix_type  FIX_MAX   = {1'b0, {(FIX_W-1){1'b1}}};
   localparam fix_type  FIX_MIN   = {1'b1, {(FIX_W-1){1'b0}}};
   localparam sum_type  SUM_MAX   = sum_type'(FIX_MAX);
   localparam sum_type  SUM_MIN   = sum_type'(FIX_MIN);
   localparam wide_type ROUND_ADD = wide_type'(1) <<< (FRAC_BITS - 1);

   // Cyclic neighbor indices used by the cross products.
   localparam int NEXT1 [3] = '{1, 2, 0};
   localparam int NEXT2 [3] = '{2, 0, 1};

   // Exact product, then round half up by dropping the fraction bits.
   function automatic prod_type qmul(input fix_type a, input fix_type b);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      p = p + ROUND_ADD;
      return prod_type'(p >>> FRAC_BITS);
   endfunction

   // Clamp a wide sum to the signed 32 bit range.
   function automatic fix_type sat32(input sum_type v);
      fix_type r;
      if (v > SUM_MAX) begin
         r = FIX_MAX;
      end else if (v < SUM_MIN) begin
         r = FIX_MIN;
      end else begin
         r = v[FIX_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/rate_feedback_torque_law_core.sv
// Rate feedback torque law core: seven stage pipelined torque evaluation
// with an APB-style register port. Depends on rftl_pkg and the defines header.
// Usage
// A request is the body rate error, the reference rate and the reference
// angular acceleration, each a signed Q15.16 3-vector on the req_ ports. It is
// taken at a rising edge where start is high and busy is low. busy is high
// in reset and the cycle after it only, so the core takes a request every cycle.
// The torque L = -P*e + r x (I*w) + I*(a - w x r) - K, with w = e + r, appears
// on the rsp_torque ports for exactly one cycle, marked by rsp_strobe, once its
// request has passed the seven register stages. Throughput is one request per
// cycle because every stage has its own multipliers and nothing is shared
// between requests: the gain product sits in the first stage, I*w with w x r
// in the second, r x h in the fourth and I*d in the fifth. The receiver cannot
// stall the core: every result is shown once and must be taken in that cycle.
// Results leave in the order their requests came in. The gain, the six inertia
// entries and the known torque are written through the APB port at byte
// address 8*i (64 bit data); the user must write them only while no request is
// in flight, which the core itself does not enforce. Synchronous reset clears
// the registers to zero and empties the pipeline.
`include "rate_feedback_torque_law_core_defines.svh"

module rate_feedback_torque_law_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  rftl_pkg::fix_type            req_rate_err_x,
   input  rftl_pkg::fix_type            req_rate_err_y,
   input  rftl_pkg::fix_type            req_rate_err_z,
   input  rftl_pkg::fix_type            req_ref_rate_x,
   input  rftl_pkg::fix_type            req_ref_rate_y,
   input  rftl_pkg::fix_type            req_ref_rate_z,
   input  rftl_pkg::fix_type            req_ref_accel_x,
   input  rftl_pkg::fix_type            req_ref_accel_y,
   input  rftl_pkg::fix_type            req_ref_accel_z,
   output logic                         rsp_strobe,
   output rftl_pkg::fix_type            rsp_torque_x,
   output rftl_pkg::fix_type            rsp_torque_y,
   output rftl_pkg::fix_type            rsp_torque_z,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rftl_pkg::ADDR_W-1:0]  paddr,
   input  logic [rftl_pkg::DATA_W-1:0]  pwdata,
   output logic [rftl_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);
   import rftl_pkg::*;

   // ---------------------------------------------------------------- control
   logic                 busy_ff;
   logic [LATENCY-1:0]   valid_ff;
   logic [LATENCY-1:0]   valid_in;
   logic                 accept;

   // --------------------------------------------------------------- registers
   logic [FIX_W-2:0]     rate_gain_ff;
   logic [2*FIX_W-1:0]   inertia_xx_yy_ff;
   logic [2*FIX_W-1:0]   inertia_zz_xy_ff;
   logic [2*FIX_W-1:0]   inertia_xz_yz_ff;
   fix_type              known_torq_ff [3];
   reg_index_type        reg_index;
   logic                 reg_write;
   fix_type              inertia [3][3];

   // -------------------------------------------------------------- datapath
   fix_type  req_e [3];
   fix_type  req_r [3];
   fix_type  req_a [3];

   // Stage 1: body rate w and the gain term.
   fix_type  r1_ff [3];
   fix_type  a1_ff [3];
   fix_type  w1_ff [3];
   fix_type  w1_in [3];
   prod_type pe1_ff [3];
   prod_type pe1_in [3];
   // Stage 2: products for I*w and w x r.
   prod_type iw2_ff [3][3];
   prod_type iw2_in [3][3];
   prod_type wr_pos2_ff [3];
   prod_type wr_pos2_in [3];
   prod_type wr_neg2_ff [3];
   prod_type wr_neg2_in [3];
   fix_type  r2_ff [3];
   fix_type  a2_ff [3];
   prod_type pe2_ff [3];
   // Stage 3: h = I*w and c2 = w x r.
   fix_type  h3_ff [3];
   fix_type  h3_in [3];
   fix_type  c2_3_ff [3];
   fix_type  c2_3_in [3];
   fix_type  r3_ff [3];
   fix_type  a3_ff [3];
   prod_type pe3_ff [3];
   // Stage 4: d = a - c2 and the products for r x h.
   fix_type  d4_ff [3];
   fix_type  d4_in [3];
   prod_type rh_pos4_ff [3];
   prod_type rh_pos4_in [3];
   prod_type rh_neg4_ff [3];
   prod_type rh_neg4_in [3];
   prod_type pe4_ff [3];
   // Stage 5: products for I*d and c1 = r x h.
   prod_type id5_ff [3][3];
   prod_type id5_in [3][3];
   fix_type  c1_5_ff [3];
   fix_type  c1_5_in [3];
   prod_type pe5_ff [3];
   // Stage 6: g = I*d and the partial sum c1 - P*e - K.
   fix_type  g6_ff [3];
   fix_type  g6_in [3];
   sum_type  part6_ff [3];
   sum_type  part6_in [3];
   // Stage 7: saturated torque.
   fix_type  torq7_ff [3];
   fix_type  torq7_in [3];

   // ------------------------------------------------------------- handshake
   // busy covers reset and the cycle after it only; the pipeline never blocks.
   assign busy     = busy_ff;
   assign accept   = start && !busy_ff;
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         valid_ff <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe   = valid_ff[LATENCY-1];
   assign rsp_torque_x = torq7_ff[0];
   assign rsp_torque_y = torq7_ff[1];
   assign rsp_torque_z = torq7_ff[2];

   // -------------------------------------------------------- register port
   // Registers sit on 8 byte boundaries; the low address bits are ignored.
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:3]);
   assign reg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_gain_ff     <= '0;
         inertia_xx_yy_ff <= '0;
         inertia_zz_xy_ff <= '0;
         inertia_xz_yz_ff <= '0;
         known_torq_ff[0] <= '0;
         known_torq_ff[1] <= '0;
         known_torq_ff[2] <= '0;
      end else if (reg_write) begin
         unique case (reg_index)
            REG_RATE_GAIN:     rate_gain_ff     <= pwdata[FIX_W-2:0];
            REG_INERTIA_XX_YY: inertia_xx_yy_ff <= pwdata;
            REG_INERTIA_ZZ_XY: inertia_zz_xy_ff <= pwdata;
            REG_INERTIA_XZ_YZ: inertia_xz_yz_ff <= pwdata;
            REG_KNOWN_TORQ_X:  known_torq_ff[0] <= pwdata[FIX_W-1:0];
            REG_KNOWN_TORQ_Y:  known_torq_ff[1] <= pwdata[FIX_W-1:0];
            REG_KNOWN_TORQ_Z:  known_torq_ff[2] <= pwdata[FIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_RATE_GAIN:     prdata = {{(DATA_W-FIX_W+1){1'b0}}, rate_gain_ff};
         REG_INERTIA_XX_YY: prdata = inertia_xx_yy_ff;
         REG_INERTIA_ZZ_XY: prdata = inertia_zz_xy_ff;
         REG_INERTIA_XZ_YZ: prdata = inertia_xz_yz_ff;
         REG_KNOWN_TORQ_X:  prdata = {{(DATA_W-FIX_W){1'b0}}, known_torq_ff[0]};
         REG_KNOWN_TORQ_Y:  prdata = {{(DATA_W-FIX_W){1'b0}}, known_torq_ff[1]};
         REG_KNOWN_TORQ_Z:  prdata = {{(DATA_W-FIX_W){1'b0}}, known_torq_ff[2]};
         default:           prdata = '0;
      endcase
   end

   // The symmetric inertia tensor unpacked from its three registers.
   always_comb begin
      inertia[0][0] = inertia_xx_yy_ff[2*FIX_W-1:FIX_W];
      inertia[1][1] = inertia_xx_yy_ff[FIX_W-1:0];
      inertia[2][2] = inertia_zz_xy_ff[2*FIX_W-1:FIX_W];
      inertia[0][1] = inertia_zz_xy_ff[FIX_W-1:0];
      inertia[1][0] = inertia_zz_xy_ff[FIX_W-1:0];
      inertia[0][2] = inertia_xz_yz_ff[2*FIX_W-1:FIX_W];
      inertia[2][0] = inertia_xz_yz_ff[2*FIX_W-1:FIX_W];
      inertia[1][2] = inertia_xz_yz_ff[FIX_W-1:0];
      inertia[2][1] = inertia_xz_yz_ff[FIX_W-1:0];
   end

   // ------------------------------------------------------ stage logic
   assign req_e[0] = req_rate_err_x;
   assign req_e[1] = req_rate_err_y;
   assign req_e[2] = req_rate_err_z;
   assign req_r[0] = req_ref_rate_x;
   assign req_r[1] = req_ref_rate_y;
   assign req_r[2] = req_ref_rate_z;
   assign req_a[0] = req_ref_accel_x;
   assign req_a[1] = req_ref_accel_y;
   assign req_a[2] = req_ref_accel_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // Stage 1: body rate and the rounded gain product.
         w1_in[i]  = sat32(sum_type'(req_e[i]) + sum_type'(req_r[i]));
         pe1_in[i] = qmul(fix_type'({1'b0, rate_gain_ff}), req_e[i]);
         // Stage 2: every term of I*w and of w x r.
         for (int j = 0; j < 3; j++) begin
            iw2_in[i][j] = qmul(inertia[i][j], w1_ff[j]);
         end
         wr_pos2_in[i] = qmul(w1_ff[NEXT1[i]], r1_ff[NEXT2[i]]);
         wr_neg2_in[i] = qmul(w1_ff[NEXT2[i]], r1_ff[NEXT1[i]]);
         // Stage 3: sums of stage 2, each saturated.
         h3_in[i]   = sat32(sum_type'(iw2_ff[i][0]) + sum_type'(iw2_ff[i][1])
                            + sum_type'(iw2_ff[i][2]));
         c2_3_in[i] = sat32(sum_type'(wr_pos2_ff[i]) - sum_type'(wr_neg2_ff[i]));
         // Stage 4: d = a - c2 beside the products of r x h.
         d4_in[i]      = sat32(sum_type'(a3_ff[i]) - sum_type'(c2_3_ff[i]));
         rh_pos4_in[i] = qmul(r3_ff[NEXT1[i]], h3_ff[NEXT2[i]]);
         rh_neg4_in[i] = qmul(r3_ff[NEXT2[i]], h3_ff[NEXT1[i]]);
         // Stage 5: every term of I*d, and c1 finished.
         for (int j = 0; j < 3; j++) begin
            id5_in[i][j] = qmul(inertia[i][j], d4_ff[j]);
         end
         c1_5_in[i] = sat32(sum_type'(rh_pos4_ff[i]) - sum_type'(rh_neg4_ff[i]));
         // Stage 6: g saturated, and the rest of the torque left unsaturated.
         g6_in[i]    = sat32(sum_type'(id5_ff[i][0]) + sum_type'(id5_ff[i][1])
                             + sum_type'(id5_ff[i][2]));
         part6_in[i] = sum_type'(c1_5_ff[i]) - sum_type'(pe5_ff[i])
                       - sum_type'(known_torq_ff[i]);
         // Stage 7: the one saturation of the full torque sum.
         torq7_in[i] = sat32(part6_ff[i] + sum_type'(g6_ff[i]));
      end
   end

   // Payload registers load every cycle; the valid bits say what is live.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         r1_ff[i]      <= req_r[i];
         a1_ff[i]      <= req_a[i];
         w1_ff[i]      <= w1_in[i];
         pe1_ff[i]     <= pe1_in[i];

         for (int j = 0; j < 3; j++) begin
            iw2_ff[i][j] <= iw2_in[i][j];
            id5_ff[i][j] <= id5_in[i][j];
         end
         wr_pos2_ff[i] <= wr_pos2_in[i];
         wr_neg2_ff[i] <= wr_neg2_in[i];
         r2_ff[i]      <= r1_ff[i];
         a2_ff[i]      <= a1_ff[i];
         pe2_ff[i]     <= pe1_ff[i];

         h3_ff[i]      <= h3_in[i];
         c2_3_ff[i]    <= c2_3_in[i];
         r3_ff[i]      <= r2_ff[i];
         a3_ff[i]      <= a2_ff[i];
         pe3_ff[i]     <= pe2_ff[i];

         d4_ff[i]      <= d4_in[i];
         rh_pos4_ff[i] <= rh_pos4_in[i];
         rh_neg4_ff[i] <= rh_neg4_in[i];
         pe4_ff[i]     <= pe3_ff[i];

         c1_5_ff[i]    <= c1_5_in[i];
         pe5_ff[i]     <= pe4_ff[i];

         g6_ff[i]      <= g6_in[i];
         part6_ff[i]   <= part6_in[i];

         torq7_ff[i]   <= torq7_in[i];
      end
   end

   // ------------------------------------------------------------ assertions
   // Every accepted request comes out as a response marked by rsp_strobe.
   `RFTL_ASSERT_DELAY(a_req_to_rsp, clock, reset, start && !busy, LATENCY, rsp_strobe, "request lost in pipeline")
   // No response appears without a matching accepted request.
   `RFTL_ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_strobe, $past(start && !busy, LATENCY), "response without request")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rate feedback torque law core: it drives torque
// requests and register writes, predicts every torque and checks each result.
// Depends on rftl_pkg and the core RTL only.
module tb;
   import rftl_pkg::*;

   // Run control.
   localparam int CYCLE_LIMIT     = 300000;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 380;
   localparam int MAX_REPORTS     = 60;

   // One request: body rate error, reference rate and reference acceleration.
   typedef struct packed {
      fix_type rate_err_x;
      fix_type rate_err_y;
      fix_type rate_err_z;
      fix_type ref_rate_x;
      fix_type ref_rate_y;
      fix_type ref_rate_z;
      fix_type ref_accel_x;
      fix_type ref_accel_y;
      fix_type ref_accel_z;
   } torque_req_type;

   typedef struct packed {
      fix_type x;
      fix_type y;
      fix_type z;
   } torque_res_type;

   logic              clock   = 1'b0;
   logic              reset   = 1'b1;
   logic              start   = 1'b0;
   logic              busy;
   torque_req_type    req_now = '0;
   logic              rsp_strobe;
   fix_type           rsp_torque_x;
   fix_type           rsp_torque_y;
   fix_type           rsp_torque_z;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0] pwdata  = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Shadow copy of the control registers, as the core should hold them.
   logic [30:0]       gain_cfg             = '0;
   logic [63:0]       inertia_cfg [3]      = '{default: '0};
   fix_type           known_torque_cfg [3] = '{default: '0};

   torque_req_type    req_pending [$];
   torque_res_type    torque_expected [$];
   logic              req_taken       = 1'b0;
   int                sender_idle_pct = 0;
   int                mismatches      = 0;
   int                requests_taken  = 0;
   int                results_checked = 0;
   int                settings_used   = 0;
   int                cycle_count     = 0;

   rate_feedback_torque_law_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rate_err_x  (req_now.rate_err_x),
      .req_rate_err_y  (req_now.rate_err_y),
      .req_rate_err_z  (req_now.rate_err_z),
      .req_ref_rate_x  (req_now.ref_rate_x),
      .req_ref_rate_y  (req_now.ref_rate_y),
      .req_ref_rate_z  (req_now.ref_rate_z),
      .req_ref_accel_x (req_now.ref_accel_x),
      .req_ref_accel_y (req_now.ref_accel_y),
      .req_ref_accel_z (req_now.ref_accel_z),
      .rsp_strobe      (rsp_strobe),
      .rsp_torque_x    (rsp_torque_x),
      .rsp_torque_y    (rsp_torque_y),
      .rsp_torque_z    (rsp_torque_z),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Torque prediction. All intermediate values are carried in 64 bits, which
   // holds any exact product of two 32 bit operands and any sum of a few rounded
   // products, so only the explicit saturation points limit the range.
   // ------------------------------------------------------------------------

   // Exact product, then the fraction bits are dropped with round half up.
   // An arithmetic right shift of a signed value is a floor.
   function automatic longint fixed_mul_round(longint a, longint b);
      return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic longint sat_to_fix(longint v);
      if (v > longint'(FIX_MAX)) begin
         return longint'(FIX_MAX);
      end else if (v < longint'(FIX_MIN)) begin
         return longint'(FIX_MIN);
      end
      return v;
   endfunction

   // L = -P*e + r x (I*w) + I*(a - w x r) - K with w = e + r. Every stage
   // vector saturates per component before it feeds the next stage.
   function automatic torque_res_type torque_law_predict(torque_req_type q);
      longint  e [3];
      longint  r [3];
      longint  a [3];
      longint  w [3];
      longint  h [3];
      longint  c1 [3];
      longint  c2 [3];
      longint  d [3];
      longint  g [3];
      longint  t [3];
      longint  m [3][3];
      longint  acc;
      fix_type ixx, iyy, izz, ixy, ixz, iyz;
      torque_res_type res;
      int      i1, i2;
      e[0] = q.rate_err_x;  e[1] = q.rate_err_y;  e[2] = q.rate_err_z;
      r[0] = q.ref_rate_x;  r[1] = q.ref_rate_y;  r[2] = q.ref_rate_z;
      a[0] = q.ref_accel_x; a[1] = q.ref_accel_y; a[2] = q.ref_accel_z;
      // The inertia tensor is symmetric; each register packs two entries.
      ixx = fix_type'(inertia_cfg[0][63:32]);
      iyy = fix_type'(inertia_cfg[0][31:0]);
      izz = fix_type'(inertia_cfg[1][63:32]);
      ixy = fix_type'(inertia_cfg[1][31:0]);
      ixz = fix_type'(inertia_cfg[2][63:32]);
      iyz = fix_type'(inertia_cfg[2][31:0]);
      m[0][0] = ixx; m[0][1] = ixy; m[0][2] = ixz;
      m[1][0] = ixy; m[1][1] = iyy; m[1][2] = iyz;
      m[2][0] = ixz; m[2][1] = iyz; m[2][2] = izz;
      for (int i = 0; i < 3; i++) begin
         w[i] = sat_to_fix(e[i] + r[i]);
      end
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            acc += fixed_mul_round(m[i][j], w[j]);
         end
         h[i] = sat_to_fix(acc);
      end
      // Both cross products share the cyclic index pattern.
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3;
         i2 = (i + 2) % 3;
         c1[i] = sat_to_fix(fixed_mul_round(r[i1], h[i2]) - fixed_mul_round(r[i2], h[i1]));
         c2[i] = sat_to_fix(fixed_mul_round(w[i1], r[i2]) - fixed_mul_round(w[i2], r[i1]));
         d[i]  = sat_to_fix(a[i] - c2[i]);
      end
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) begin
            acc += fixed_mul_round(m[i][j], d[j]);
         end
         g[i] = sat_to_fix(acc);
      end
      for (int i = 0; i < 3; i++) begin
         t[i] = sat_to_fix(-fixed_mul_round(longint'(gain_cfg), e[i]) + c1[i] + g[i]
                           - longint'(known_torque_cfg[i]));
      end
      res.x = fix_type'(t[0]);
      res.y = fix_type'(t[1]);
      res.z = fix_type'(t[2]);
      return res;
   endfunction

   // Counts a failure and tells whether it should still be printed, so that
   // a badly broken core cannot flood the log.
   function automatic bit note_mismatch();
      mismatches++;
      if (mismatches == MAX_REPORTS + 1) begin
         $display("%0t: further mismatches are counted but not shown", $time);
      end
      return mismatches <= MAX_REPORTS;
   endfunction

   task automatic check_axis(string axis, fix_type want, fix_type got);
      if (want !== got) begin
         if (note_mismatch()) begin
            $display("%0t: torque_%s expected %0d (%h), got %0d (%h)",
                     $time, axis, want, want, got, got);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Register port. Each write is followed by a read of the same address, and
   // the implemented bits of the read value are compared with the shadow.
   // Bits above a register's width are dropped on the way in.
   // ------------------------------------------------------------------------

   function automatic logic [DATA_W-1:0] reg_bits(reg_index_type idx);
      case (idx)
         REG_RATE_GAIN:     return 64'h0000_0000_7FFF_FFFF;
         REG_INERTIA_XX_YY,
         REG_INERTIA_ZZ_XY,
         REG_INERTIA_XZ_YZ: return 64'hFFFF_FFFF_FFFF_FFFF;
         REG_KNOWN_TORQ_X,
         REG_KNOWN_TORQ_Y,
         REG_KNOWN_TORQ_Z:  return 64'h0000_0000_FFFF_FFFF;
         default:           return 64'h0;
      endcase
   endfunction

   task automatic write_control_reg(reg_index_type idx, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] kept;
      kept = value & reg_bits(idx);
      // Setup phase, then access phase; the write lands when pready is high.
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_RATE_GAIN:     gain_cfg            = kept[30:0];
         REG_INERTIA_XX_YY: inertia_cfg[0]      = kept;
         REG_INERTIA_ZZ_XY: inertia_cfg[1]      = kept;
         REG_INERTIA_XZ_YZ: inertia_cfg[2]      = kept;
         REG_KNOWN_TORQ_X:  known_torque_cfg[0] = kept[31:0];
         REG_KNOWN_TORQ_Y:  known_torque_cfg[1] = kept[31:0];
         REG_KNOWN_TORQ_Z:  known_torque_cfg[2] = kept[31:0];
         default:           ;
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx != REG_NONE && (prdata & reg_bits(idx)) !== kept) begin
         if (note_mismatch()) begin
            $display("%0t: register %s read expected %h, got %h",
                     $time, idx.name(), kept, prdata & reg_bits(idx));
         end
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_config(logic [DATA_W-1:0] gain, logic [DATA_W-1:0] xx_yy,
                                 logic [DATA_W-1:0] zz_xy, logic [DATA_W-1:0] xz_yz,
                                 logic [DATA_W-1:0] kx, logic [DATA_W-1:0] ky,
                                 logic [DATA_W-1:0] kz);
      write_control_reg(REG_RATE_GAIN, gain);
      write_control_reg(REG_INERTIA_XX_YY, xx_yy);
      write_control_reg(REG_INERTIA_ZZ_XY, zz_xy);
      write_control_reg(REG_INERTIA_XZ_YZ, xz_yz);
      write_control_reg(REG_KNOWN_TORQ_X, kx);
      write_control_reg(REG_KNOWN_TORQ_Y, ky);
      write_control_reg(REG_KNOWN_TORQ_Z, kz);
      settings_used++;
   endtask

   // ------------------------------------------------------------------------
   // Random values. Most values are small enough that the torque stays in
   // range and the rounding shows; the rest are full width or the extremes,
   // which drive the saturation paths and toggle every bit.
   // ------------------------------------------------------------------------

   function automatic fix_type rand_span(int unsigned span);
      return fix_type'(longint'($urandom_range(0, 2 * span)) - longint'(span));
   endfunction

   function automatic fix_type rand_extreme();
      case ($urandom_range(0, 4))
         0:       return FIX_MAX;
         1:       return FIX_MIN;
         2:       return '0;
         3:       return -1;
         default: return 1;
      endcase
   endfunction

   function automatic fix_type rand_fix();
      case ($urandom_range(0, 9))
         0, 1, 2: return rand_span(1 << 16);
         3, 4, 5: return rand_span(1 << 20);
         6:       return rand_span(1 << 24);
         7, 8:    return fix_type'($urandom);
         default: return rand_extreme();
      endcase
   endfunction

   function automatic torque_req_type make_req(fix_type ex, fix_type ey, fix_type ez,
                                               fix_type rx, fix_type ry, fix_type rz,
                                               fix_type ax, fix_type ay, fix_type az);
      torque_req_type q;
      q.rate_err_x  = ex; q.rate_err_y  = ey; q.rate_err_z  = ez;
      q.ref_rate_x  = rx; q.ref_rate_y  = ry; q.ref_rate_z  = rz;
      q.ref_accel_x = ax; q.ref_accel_y = ay; q.ref_accel_z = az;
      return q;
   endfunction

   function automatic torque_req_type rand_req();
      return make_req(rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                      rand_fix(), rand_fix(), rand_fix(), rand_fix());
   endfunction

   // Register settings for the random phases: moderate values where the law
   // works unsaturated, fully random words, an identity inertia with zero gain,
   // and words drawn from the extremes.
   task automatic randomize_config(int mode);
      case (mode % 4)
         0: program_config(64'($urandom_range(0, 1 << 18)),
                           {rand_span(1 << 18), rand_span(1 << 18)},
                           {rand_span(1 << 18), rand_span(1 << 18)},
                           {rand_span(1 << 18), rand_span(1 << 18)},
                           {32'($urandom), rand_span(1 << 20)},
                           {32'($urandom), rand_span(1 << 20)},
                           {32'($urandom), rand_span(1 << 20)});
         1: program_config({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
         2: program_config(64'h0, {32'h0001_0000, 32'h0001_0000},
                           {32'h0001_0000, 32'h0}, 64'h0,
                           64'(FIX_MIN), 64'(FIX_MIN), 64'(FIX_MIN));
         default: program_config({$urandom, rand_extreme()},
                                 {rand_extreme(), rand_extreme()},
                                 {rand_extreme(), rand_extreme()},
                                 {rand_extreme(), rand_extreme()},
                                 64'(rand_extreme()), 64'(rand_extreme()),
                                 64'(rand_extreme()));
      endcase
   endtask

   // Waits until every queued request has gone in and every torque is back.
   // Each request yields exactly one result, so the core is idle after that.
   task automatic wait_for_drain();
      @(posedge clock);
      while (req_pending.size() != 0 || start || torque_expected.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver. A request stays on the ports until the core takes it;
   // between requests the sender may idle, at the rate set for the phase.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (req_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_now <= req_pending.pop_front();
            start   <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. A request taken at this edge is predicted at once with the
   // current register shadow; a torque shown in this cycle is checked against
   // the oldest prediction. Results must come back in request order.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : torque_monitor
      torque_res_type want;
      req_taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         torque_expected.push_back(torque_law_predict(req_now));
         requests_taken++;
      end
      if (!reset && rsp_strobe) begin
         if (torque_expected.size() == 0) begin
            if (note_mismatch()) begin
               $display("%0t: torque result with none expected: %h %h %h", $time,
                        rsp_torque_x, rsp_torque_y, rsp_torque_z);
            end
         end else begin
            want = torque_expected.pop_front();
            check_axis("x", want.x, rsp_torque_x);
            check_axis("y", want.y, rsp_torque_y);
            check_axis("z", want.z, rsp_torque_z);
            results_checked++;
         end
      end
   end

   // A hung core or handshake ends the run here.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d torques still awaited",
                  cycle_count, torque_expected.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence. Directed requests come first, under the reset register
   // values, a hand-picked setting and a saturating setting; then random
   // phases, each with its own setting and sender idle rate.
   // ------------------------------------------------------------------------
   initial begin : test_sequence
      int idle_plan [4];
      idle_plan = '{0, 45, 0, 35};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With every register at zero the torque must be zero whatever comes in.
      req_pending.push_back(make_req(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
                                     FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
      req_pending.push_back(make_req(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                                     FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
      req_pending.push_back(make_req(FIX_MAX, FIX_MIN, -1, 1, FIX_MIN, FIX_MAX,
                                     32'h0001_8000, -32'sh8000, 0));
      wait_for_drain();

      // Hand-picked setting: gain 1.0, a full inertia tensor with an off
      // diagonal of one LSB so that exact half LSB products show the rounding.
      program_config(64'h0001_0000, {32'h0002_0000, 32'h0001_0000},
                     {32'h0001_8000, 32'h0000_8000}, {32'hFFFF_C000, 32'h0000_0001},
                     64'h1, 64'(-32'sh1_0000), 64'h0);
      sender_idle_pct = 45;
      req_pending.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(make_req(1, -1, 0, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(make_req(0, 0, 0, 32'h8000, -32'sh8000, 32'h1_8000, 0, 0, 0));
      req_pending.push_back(make_req(32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000));
      req_pending.push_back(make_req(-32'sh8000, 32'h8000, -1, 1, -1, 32'h8000,
                                     32'h8000, -32'sh8000, 1));
      req_pending.push_back(make_req(0, 0, 0, 0, 0, 0, FIX_MAX, FIX_MIN, 0));
      // The body rate sum saturates in both directions.
      req_pending.push_back(make_req(FIX_MAX, FIX_MAX, FIX_MAX, 1, 1, 1, 0, 0, 0));
      req_pending.push_back(make_req(FIX_MIN, FIX_MIN, FIX_MIN, -1, -1, -1, 0, 0, 0));
      // Large reference rates overflow the cross products.
      req_pending.push_back(make_req(0, 0, 0, 32'h7FFF_0000, -32'sh7FFF_0000, 32'h1_0000,
                                     0, 0, 0));
      wait_for_drain();

      // Saturating setting. The gain word carries bits above the register
      // width, the known torques carry junk in the upper half, and a write to
      // the unused address must change nothing.
      program_config(64'hFFFF_FFFF_FFFF_FFFF, {FIX_MAX, FIX_MIN}, {FIX_MAX, FIX_MAX},
                     {FIX_MIN, FIX_MIN}, {32'hDEAD_BEEF, FIX_MIN},
                     {32'h1234_5678, FIX_MAX}, 64'hFFFF_FFFF_FFFF_FFFF);
      write_control_reg(REG_NONE, {$urandom, $urandom});
      sender_idle_pct = 0;
      req_pending.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
      req_pending.push_back(make_req(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX,
                                     FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
      req_pending.push_back(make_req(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                                     FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
      req_pending.push_back(make_req(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MIN,
                                     FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX));
      req_pending.push_back(make_req(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX,
                                     FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN));
      req_pending.push_back(make_req(1, 1, 1, -1, -1, -1, 32'h8000, 32'h8000, 32'h8000));
      req_pending.push_back(make_req(32'h8000, -32'sh8000, 1, 2, -2, 0, 0, 0, 0));
      wait_for_drain();

      // Random phases. The idle rate rotates so that gaps fall on every stage
      // of the pipeline, with back-to-back stretches in between.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         randomize_config(p);
         if (p == 2) begin
            write_control_reg(REG_NONE, {$urandom, $urandom});
         end
         sender_idle_pct = idle_plan[p % 4];
         @(posedge clock);
         repeat (ITEMS_PER_PHASE) req_pending.push_back(rand_req());
         wait_for_drain();
      end

      // Any stray result would show up within the pipeline depth.
      repeat (LATENCY + 4) @(posedge clock);
      $display("tb: %0d torque requests taken, %0d results checked", requests_taken,
               results_checked);
      $display("tb: %0d register settings, including zero, saturating and masked words",
               settings_used);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
